### sv/eskd_pkg.sv
// ----------------------------------------------------------------------------
// eskd_pkg
// Shared types, constants, parse tables and helper functions for the
// escape sequence key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package eskd_pkg;

  localparam int BufDepth = 32;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int FillW    = $clog2(BufDepth + 1);
  localparam int NumKeys  = 22;
  localparam int PfxLen   = 4;
  localparam int CmpW     = (FillW > 5) ? FillW : 5;

  localparam logic [4:0] LimitReset = 5'd31;
  localparam logic [7:0] ChOne      = 8'h31;
  localparam logic [7:0] ChTwo      = 8'h32;
  localparam logic [7:0] ChEight    = 8'h38;

  typedef enum logic [2:0] {
    EV_LB, EV_SEMI, EV_NUM, EV_LETTER, EV_TILDE, EV_OH, EV_EXC
  } ev_e;

  typedef enum logic [3:0] {
    ACT_FIRST, ACT_SWITCH, ACT_TOMETA, ACT_TOCM, ACT_CODE, ACT_MLET, ACT_MCODE,
    ACT_MOPT, ACT_DONE, ACT_OPT, ACT_BAD, ACT_EXC, ACT_ONE
  } act_e;

  // parser transition table: [parse state][byte class]
  localparam act_e ActTable [8][7] = '{
    '{ACT_FIRST, ACT_BAD,    ACT_BAD,    ACT_BAD,  ACT_BAD,  ACT_OPT, ACT_EXC},
    '{ACT_BAD,   ACT_BAD,    ACT_SWITCH, ACT_DONE, ACT_BAD,  ACT_BAD, ACT_EXC},
    '{ACT_BAD,   ACT_TOMETA, ACT_ONE,    ACT_BAD,  ACT_BAD,  ACT_BAD, ACT_EXC},
    '{ACT_BAD,   ACT_BAD,    ACT_MLET,   ACT_BAD,  ACT_BAD,  ACT_BAD, ACT_EXC},
    '{ACT_BAD,   ACT_BAD,    ACT_BAD,    ACT_DONE, ACT_BAD,  ACT_BAD, ACT_EXC},
    '{ACT_BAD,   ACT_TOCM,   ACT_CODE,   ACT_BAD,  ACT_DONE, ACT_BAD, ACT_EXC},
    '{ACT_BAD,   ACT_BAD,    ACT_MCODE,  ACT_BAD,  ACT_BAD,  ACT_BAD, ACT_EXC},
    '{ACT_BAD,   ACT_BAD,    ACT_MOPT,   ACT_DONE, ACT_BAD,  ACT_BAD, ACT_EXC}
  };

  // key patterns, first character in the low byte
  localparam logic [31:0] KeyPat [NumKeys] = '{
    32'h0000_415B, 32'h0000_425B, 32'h0000_435B, 32'h0000_445B,
    32'h0000_465B, 32'h0000_485B,
    32'h007E_325B, 32'h007E_335B, 32'h007E_355B, 32'h007E_365B,
    32'h0000_504F, 32'h0000_514F, 32'h0000_524F, 32'h0000_534F,
    32'h7E35_315B, 32'h7E37_315B, 32'h7E38_315B, 32'h7E39_315B,
    32'h7E30_325B, 32'h7E31_325B, 32'h7E33_325B, 32'h7E34_325B
  };

  localparam logic [2:0] KeyLen [NumKeys] = '{
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3,
    3'd2, 3'd2, 3'd2, 3'd2,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };

  // microprogram steps
  typedef enum logic [3:0] {
    ST_WAIT, ST_EXEC, ST_PUTC, ST_TEST, ST_MATCH, ST_READ, ST_PUSH, ST_LOOP,
    ST_CLEAR
  } step_e;

  typedef enum logic [2:0] {
    OP_NOP, OP_LATCH, OP_EXEC, OP_PUTC, OP_MATCH, OP_READ, OP_PUSH, OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS, C_ACCEPT, C_SECOND, C_NOTDONE, C_STALL, C_MORE
  } cond_e;

  typedef struct packed {
    logic  in_rdy;
    op_e   op;
    cond_e cond;
    step_e target;
    step_e next;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic second;
    logic notdone;
    logic stall;
    logic more;
  } flags_t;

  function automatic ev_e classify(input logic kind, input logic [7:0] c);
    ev_e ev;
    if (kind || c == 8'h00)                        ev = EV_EXC;
    else if (c == 8'h5B)                           ev = EV_LB;
    else if (c == 8'h3B)                           ev = EV_SEMI;
    else if (c == 8'h7E)                           ev = EV_TILDE;
    else if (c == 8'h4F)                           ev = EV_OH;
    else if (c >= 8'h30 && c <= 8'h39)             ev = EV_NUM;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
                                                   ev = EV_LETTER;
    else                                           ev = EV_EXC;
    return ev;
  endfunction

  function automatic logic [2:0] meta_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - ChOne;
    return (c >= ChTwo && c <= ChEight) ? diff[2:0] : 3'd0;
  endfunction

  function automatic logic [4:0] match_key(input logic [PfxLen-1:0][7:0] pfx,
                                           input logic [FillW-1:0]        fill);
    logic [4:0]  key;
    logic [31:0] mask;
    key = 5'd0;
    // descending so the first pattern in the list wins
    for (int i = NumKeys - 1; i >= 0; i--) begin
      mask = (KeyLen[i] == 3'd2) ? 32'h0000_FFFF :
             (KeyLen[i] == 3'd3) ? 32'h00FF_FFFF : 32'hFFFF_FFFF;
      if (fill == FillW'(KeyLen[i]) && ((pfx & mask) == KeyPat[i])) begin
        key = 5'(i + 1);
      end
    end
    return key;
  endfunction

endpackage

`default_nettype wire

### sv/escape_sequence_key_decoder_core.sv
// ----------------------------------------------------------------------------
// escape_sequence_key_decoder_core
// Parses the bytes after an ESC into cursor, edit and function keys; unmatched
// sequences hand their text back one character per result.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata rx_byte, tuser kind
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata key/meta/len/char,
//                                               tuser has_char, tlast last
//  cfg       in   cfg_valid_i/cfg_ready_o       text_limit
//
//  A byte that does not finish a sequence passes the wait, execute and test
//  steps, or wait, execute and the extra store step for a code byte after
//  "[1". A finished sequence then runs the match step, the read, push and
//  loop steps per result (one read of the single text store port each), and
//  the clear step. Output stalls hold the emit step; the next byte is taken
//  after the final loop and clear steps. Reset: idle parser, text_limit 31.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_key_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [4:0] key_code, [7:5] meta_code,
                                           // [12:8] text_len, [20:13] text_char
  output logic             m_axis_tuser,   // [0] has_char
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i
);
  import eskd_pkg::*;

  uword_t ctrl;
  flags_t flags;

  eskd_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // control state
  logic [4:0]       limit_q;
  logic [2:0]       pstate_q, pstate_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [2:0]       mod_q, mod_d;
  logic             too_long_q, too_long_d;
  logic             done_q, done_d;
  logic             try_q, try_d;
  logic [4:0]       k_q;
  logic             ovalid_q;

  // datapath payload
  logic [7:0]              byte_q;
  ev_e                     ev_q;
  logic [PfxLen-1:0][7:0]  pfx_q;
  logic [7:0]              mem [BufDepth];
  logic [7:0]              rd_q;
  logic [4:0]              key_q;
  logic [4:0]              len_q;
  logic [23:0]             odata_q;
  logic                    ohas_q;
  logic                    olast_q;

  act_e             act;
  logic             put_en;
  logic [7:0]       put_val;
  logic             put_ok;
  logic             accept;
  logic             load;
  logic [4:0]       key_d;
  logic [CmpW-1:0]  base;
  logic [4:0]       len_d;

  assign accept = s_axis_tvalid & ctrl.in_rdy;
  assign act    = ActTable[pstate_q][ev_q];
  assign load   = (ctrl.op == OP_PUSH) && (!ovalid_q || m_axis_tready);
  assign put_ok = fill_q < FillW'(BufDepth);

  assign flags.accept  = accept;
  assign flags.second  = (ctrl.op == OP_EXEC) && (act == ACT_ONE);
  assign flags.notdone = !done_q;
  assign flags.stall   = ovalid_q && !m_axis_tready;
  assign flags.more    = (len_q != 5'd0) && (k_q < len_q);

  // parser step
  always_comb begin
    pstate_d = pstate_q;
    mod_d    = mod_q;
    done_d   = done_q;
    try_d    = try_q;
    put_en   = 1'b0;
    put_val  = byte_q;
    unique case (ctrl.op)
      OP_EXEC: begin
        done_d = 1'b0;
        try_d  = 1'b0;
        unique case (act)
          ACT_FIRST:  begin put_en = 1'b1; pstate_d = 3'd1; end
          ACT_SWITCH: begin
            if (byte_q == ChOne) begin
              pstate_d = 3'd2;
            end else begin
              put_en   = 1'b1;
              pstate_d = 3'd5;
            end
          end
          ACT_TOMETA: pstate_d = 3'd3;
          ACT_TOCM:   pstate_d = 3'd6;
          ACT_CODE:   begin put_en = 1'b1; pstate_d = 3'd5; end
          ACT_MLET:   begin mod_d = meta_of(byte_q); pstate_d = 3'd4; end
          ACT_MCODE:  begin mod_d = meta_of(byte_q); pstate_d = 3'd5; end
          ACT_MOPT:   begin mod_d = meta_of(byte_q); pstate_d = 3'd7; end
          ACT_DONE:   begin put_en = 1'b1; done_d = 1'b1; try_d = 1'b1; end
          ACT_OPT:    begin put_en = 1'b1; pstate_d = 3'd7; end
          ACT_BAD:    begin put_en = 1'b1; done_d = 1'b1; end
          ACT_EXC:    done_d = 1'b1;
          ACT_ONE:    begin put_en = 1'b1; put_val = ChOne; pstate_d = 3'd5; end
          default:    done_d = 1'b1;
        endcase
      end
      OP_PUTC: put_en = 1'b1;  // byte after the implied '1'
      OP_CLEAR: begin
        pstate_d = 3'd0;
        mod_d    = 3'd0;
        done_d   = 1'b0;
        try_d    = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    fill_d     = fill_q;
    too_long_d = too_long_q;
    if (ctrl.op == OP_CLEAR) begin
      fill_d     = '0;
      too_long_d = 1'b0;
    end else if (put_en) begin
      if (put_ok) fill_d = fill_q + 1'b1;
      else        too_long_d = 1'b1;
    end
  end

  // key match and text length
  always_comb begin
    key_d = (try_q && !too_long_q) ? match_key(pfx_q, fill_q) : 5'd0;
    base  = (key_d != 5'd0) ? '0 : CmpW'(fill_q);
    len_d = (base > CmpW'(limit_q)) ? limit_q : base[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= LimitReset;
      pstate_q   <= 3'd0;
      fill_q     <= '0;
      mod_q      <= 3'd0;
      too_long_q <= 1'b0;
      done_q     <= 1'b0;
      try_q      <= 1'b0;
      k_q        <= 5'd0;
      ovalid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      pstate_q   <= pstate_d;
      fill_q     <= fill_d;
      mod_q      <= mod_d;
      too_long_q <= too_long_d;
      done_q     <= done_d;
      try_q      <= try_d;
      if (ctrl.op == OP_MATCH) k_q <= 5'd0;
      else if (load)           k_q <= k_q + 5'd1;
      if (load)               ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata;
      ev_q   <= classify(s_axis_tuser, s_axis_tdata);
    end
    if (put_en && put_ok) begin
      mem[fill_q[AddrW-1:0]] <= put_val;
      if (fill_q < FillW'(PfxLen)) pfx_q[fill_q[1:0]] <= put_val;
    end
    if (ctrl.op == OP_READ) rd_q <= mem[AddrW'(k_q)];
    if (ctrl.op == OP_MATCH) begin
      key_q <= key_d;
      len_q <= len_d;
    end
    if (load) begin
      odata_q <= {3'd0, (len_q == 5'd0) ? 8'd0 : rd_q, len_q, mod_q, key_q};
      ohas_q  <= len_q != 5'd0;
      olast_q <= (len_q == 5'd0) || (k_q + 5'd1 == len_q);
    end
  end

  assign s_axis_tready = ctrl.in_rdy;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ohas_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

### sv/eskd_useq.sv
// ----------------------------------------------------------------------------
// eskd_useq
// Microprogram sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module eskd_useq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire eskd_pkg::flags_t flags_i,
  output eskd_pkg::uword_t     ctrl_o
);
  import eskd_pkg::*;

  step_e  step_q, step_d;
  uword_t uw;
  logic   take;

  // control store
  always_comb begin
    unique case (step_q)
      ST_WAIT:  uw = '{1'b1, OP_LATCH, C_ACCEPT,  ST_EXEC,  ST_WAIT};
      ST_EXEC:  uw = '{1'b0, OP_EXEC,  C_SECOND,  ST_PUTC,  ST_TEST};
      ST_PUTC:  uw = '{1'b0, OP_PUTC,  C_ALWAYS,  ST_WAIT,  ST_WAIT};
      ST_TEST:  uw = '{1'b0, OP_NOP,   C_NOTDONE, ST_WAIT,  ST_MATCH};
      ST_MATCH: uw = '{1'b0, OP_MATCH, C_ALWAYS,  ST_READ,  ST_READ};
      ST_READ:  uw = '{1'b0, OP_READ,  C_ALWAYS,  ST_PUSH,  ST_PUSH};
      ST_PUSH:  uw = '{1'b0, OP_PUSH,  C_STALL,   ST_PUSH,  ST_LOOP};
      ST_LOOP:  uw = '{1'b0, OP_NOP,   C_MORE,    ST_READ,  ST_CLEAR};
      ST_CLEAR: uw = '{1'b0, OP_CLEAR, C_ALWAYS,  ST_WAIT,  ST_WAIT};
      default:  uw = '{1'b0, OP_NOP,   C_ALWAYS,  ST_WAIT,  ST_WAIT};
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:  take = 1'b1;
      C_ACCEPT:  take = flags_i.accept;
      C_SECOND:  take = flags_i.second;
      C_NOTDONE: take = flags_i.notdone;
      C_STALL:   take = flags_i.stall;
      C_MORE:    take = flags_i.more;
      default:   take = 1'b1;
    endcase
    step_d = take ? uw.target : uw.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = uw;

endmodule

`default_nettype wire
